/* design/tlht_pkg.sv */
`default_nettype none
package tlht_pkg;

    localparam int TABLE_SLOTS_DEF = 256;
    localparam int LAYER_KINDS_DEF = 4;

    localparam logic [31:0] HASH_SEED = 32'd2166136261;
    localparam logic [31:0] HASH_GOLD = 32'h9e3779b9;

    // request codes
    localparam logic [2:0] REQ_BEGIN   = 3'd0;
    localparam logic [2:0] REQ_TRANS   = 3'd1;
    localparam logic [2:0] REQ_MARK    = 3'd2;
    localparam logic [2:0] REQ_CONSUME = 3'd3;
    localparam logic [2:0] REQ_SWEEP   = 3'd4;

    // result status codes
    localparam logic [2:0] STS_CHANGED = 3'd0;
    localparam logic [2:0] STS_SAME    = 3'd1;
    localparam logic [2:0] STS_ILLEGAL = 3'd2;
    localparam logic [2:0] STS_BADARG  = 3'd3;
    localparam logic [2:0] STS_NOSLOT  = 3'd4;

    // lifecycle states
    localparam logic [2:0] LC_ABSENT = 3'd0;
    localparam logic [2:0] LC_RENDER = 3'd4;
    localparam logic [2:0] LC_STALE  = 3'd5;

    // one table entry; tag: bit0 occupied, 3:1 kind, 6:4 band, 11:7 zoom
    // stat: 2:0 state, 3 cpu, 4 gpu, 5 fallback, 6 ideal, 7 drop pending
    typedef struct packed {
        logic [11:0] tag;
        logic [30:0] col;
        logic [30:0] row;
        logic [7:0]  stat;
        logic [31:0] frame;
    } slot_t;

    function automatic logic [31:0] hash_mix(input logic [31:0] h, input logic [31:0] v);
        return h ^ (v + HASH_GOLD + (h << 6) + (h >> 2));
    endfunction

    // legal target set for each current state
    function automatic logic [7:0] legal_moves(input logic [2:0] st);
        logic [7:0] m;
        case (st)
            3'd0: m = 8'h03;
            3'd1: m = 8'h26;
            3'd2: m = 8'h3C;
            3'd3: m = 8'h38;
            3'd4: m = 8'h3A;
            3'd5: m = 8'h32;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

/* design/tlht_ram.sv */
`default_nettype none
module tlht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write one word when enabled; always read the addressed word
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

/* design/tile_lifecycle_hash_table.sv */
`default_nettype none
// Tile lifecycle table: a hashed, linearly probed table of TABLE_SLOTS tile
// entries held in one single-port RAM, each with a checked six-state
// lifecycle, flags and a drop-pending bit. One request is taken at a time
// and gives one result beat. After reset the block clears every slot of the
// table before s_ready rises. A result beat held by m_ready stalls the next
// result until it is taken. A begin-frame or a rejected request goes from
// accept straight to the result. A keyed request is accepted, hashed over
// its five key fields and reduced to its home slot by a reciprocal multiply;
// it then probes slots, each a RAM read then a compare, then writes the
// entry back and gives its result; a consume that meets an empty slot skips
// the write. A stale sweep reads every slot in turn. Counters wrap at 32
// bits; the result register frees the input side as soon as the result is
// loaded.
module tile_lifecycle_hash_table
    import tlht_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int LAYER_KINDS = LAYER_KINDS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_req_type,
    input  wire logic [2:0]  s_layer_kind,
    input  wire logic [4:0]  s_zoom_level,
    input  wire logic [30:0] s_tile_x,
    input  wire logic [30:0] s_tile_y,
    input  wire logic [2:0]  s_zoom_band,
    input  wire logic [2:0]  s_next_state,
    input  wire logic [3:0]  s_flag_bits,
    input  wire logic [30:0] s_right_x,
    input  wire logic [30:0] s_bottom_y,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic             m_retry,
    output logic [31:0]      m_frame_number,
    output logic [31:0]      m_frame_transitions,
    output logic [31:0]      m_frame_invalid,
    output logic [31:0]      m_invalid_total,
    output logic [31:0]      m_ideal_count,
    output logic [31:0]      m_fallback_count,
    output logic [31:0]      m_target_state_count
);
    localparam int IW = $clog2(TABLE_SLOTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SLOTS - 1);
    localparam logic [IW:0]   SLOTS_W  = (IW+1)'(TABLE_SLOTS);
    localparam logic [3:0]    KINDS_W  = 4'(LAYER_KINDS);
    // reciprocal of the slot count, exact for every 32-bit hash
    localparam logic [64:0]   RECIP    = ((65'd1 << (32 + IW)) / 65'(TABLE_SLOTS)) + 65'd1;
    localparam logic [31:0]   RECIP_LO = RECIP[31:0];
    localparam logic          RECIP_HI = RECIP[32];
    localparam logic [31:0]   SLOTS_32 = 32'(TABLE_SLOTS);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_HASH, S_MOD, S_RD, S_CHK, S_APPLY, S_SW_RD, S_SW_CHK, S_FIN
    } state_t;

    state_t        state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] fb_idx_reg, fb_idx_next;
    logic          fb_vld_reg, fb_vld_next;
    logic [31:0]   fb_frame_reg, fb_frame_next;
    logic [IW:0]   cnt_reg, cnt_next;
    logic [4:0]    step_reg, step_next;
    logic [31:0]   h_reg, h_next;
    logic [64:0]   prod_reg, prod_next;
    logic [31:0]   qn_reg, qn_next;

    logic [2:0]    req_reg, req_next;
    logic [2:0]    kind_reg, kind_next;
    logic [4:0]    z_reg, z_next;
    logic [30:0]   x_reg, x_next;
    logic [30:0]   y_reg, y_next;
    logic [2:0]    band_reg, band_next;
    logic [2:0]    nst_reg, nst_next;
    logic [3:0]    flags_reg, flags_next;
    logic [30:0]   rx_reg, rx_next;
    logic [30:0]   by_reg, by_next;

    slot_t         ent_reg, ent_next;
    logic [2:0]    sts_reg, sts_next;
    logic          retry_reg, retry_next;

    logic [31:0]   fc_reg, fc_next;
    logic [31:0]   stat_reg [5];
    logic [31:0]   stat_next [5];
    logic [31:0]   per_reg [6];
    logic [31:0]   per_next [6];

    logic          m_valid_reg, m_valid_next;
    logic [2:0]    m_status_reg, m_status_next;
    logic          m_retry_reg, m_retry_next;
    logic [31:0]   m_fn_reg, m_fn_next;
    logic [31:0]   m_ft_reg, m_ft_next;
    logic [31:0]   m_fi_reg, m_fi_next;
    logic [31:0]   m_it_reg, m_it_next;
    logic [31:0]   m_id_reg, m_id_next;
    logic [31:0]   m_fb_reg, m_fb_next;
    logic [31:0]   m_tc_reg, m_tc_next;

    logic          ram_we;
    logic [IW-1:0] ram_addr;
    slot_t         ram_wdata;
    slot_t         rd_ent;

    // working values
    logic [31:0]   mix_v;
    logic [63:0]   mul_lo;
    logic [31:0]   quo;
    logic [31:0]   rem_w;
    logic [IW-1:0] idx_inc;
    logic [11:0]   key_tag;
    logic          create;
    logic          fb_take;
    logic [IW-1:0] fb_sel;
    logic [2:0]    prev_st;
    logic [7:0]    legal_set;
    logic          legal;
    logic          in_win;
    logic          move;
    logic [2:0]    tgt;
    slot_t         new_ent;

    tlht_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (rd_ent)
    );

    assign s_ready              = (state_reg == S_IDLE);
    assign m_valid              = m_valid_reg;
    assign m_status             = m_status_reg;
    assign m_retry              = m_retry_reg;
    assign m_frame_number       = m_fn_reg;
    assign m_frame_transitions  = m_ft_reg;
    assign m_frame_invalid      = m_fi_reg;
    assign m_invalid_total      = m_it_reg;
    assign m_ideal_count        = m_id_reg;
    assign m_fallback_count     = m_fb_reg;
    assign m_target_state_count = m_tc_reg;

    assign idx_inc   = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
    assign key_tag   = {z_reg, band_reg, kind_reg, 1'b1};
    assign create    = (req_reg == REQ_TRANS) || (req_reg == REQ_MARK);
    assign prev_st   = ent_reg.stat[2:0];
    assign legal_set = legal_moves(prev_st);
    assign legal     = legal_set[nst_reg];

    // sequence one request
    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        fb_idx_next   = fb_idx_reg;
        fb_vld_next   = fb_vld_reg;
        fb_frame_next = fb_frame_reg;
        cnt_next      = cnt_reg;
        step_next     = step_reg;
        h_next        = h_reg;
        prod_next     = prod_reg;
        qn_next       = qn_reg;
        req_next      = req_reg;
        kind_next     = kind_reg;
        z_next        = z_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        band_next     = band_reg;
        nst_next      = nst_reg;
        flags_next    = flags_reg;
        rx_next       = rx_reg;
        by_next       = by_reg;
        ent_next      = ent_reg;
        sts_next      = sts_reg;
        retry_next    = retry_reg;
        fc_next       = fc_reg;
        stat_next     = stat_reg;
        per_next      = per_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_retry_next  = m_retry_reg;
        m_fn_next     = m_fn_reg;
        m_ft_next     = m_ft_reg;
        m_fi_next     = m_fi_reg;
        m_it_next     = m_it_reg;
        m_id_next     = m_id_reg;
        m_fb_next     = m_fb_reg;
        m_tc_next     = m_tc_reg;
        ram_we        = 1'b0;
        ram_addr      = idx_reg;
        ram_wdata     = ent_reg;
        mix_v         = '0;
        mul_lo        = '0;
        quo           = '0;
        rem_w         = '0;
        fb_take       = 1'b0;
        fb_sel        = fb_idx_reg;
        in_win        = 1'b0;
        move          = 1'b0;
        tgt           = nst_reg;
        new_ent       = ent_reg;

        // drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                idx_next  = idx_inc;
                if (idx_reg == LAST_IDX) begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE: begin
                if (s_valid) begin
                    req_next   = s_req_type;
                    kind_next  = s_layer_kind;
                    z_next     = s_zoom_level;
                    x_next     = s_tile_x;
                    y_next     = s_tile_y;
                    band_next  = s_zoom_band;
                    nst_next   = s_next_state;
                    flags_next = s_flag_bits;
                    rx_next    = s_right_x;
                    by_next    = s_bottom_y;
                    retry_next = 1'b0;
                    h_next     = HASH_SEED;
                    step_next  = '0;
                    idx_next   = '0;
                    state_next = S_FIN;
                    sts_next   = STS_BADARG;
                    case (s_req_type)
                        REQ_BEGIN: begin
                            fc_next      = fc_reg + 1'b1;
                            stat_next[0] = '0;
                            stat_next[1] = '0;
                            stat_next[3] = '0;
                            stat_next[4] = '0;
                            for (int i = 0; i < 6; i++) begin
                                per_next[i] = '0;
                            end
                            sts_next = STS_CHANGED;
                        end
                        REQ_TRANS: begin
                            if ({1'b0, s_layer_kind} < KINDS_W && s_next_state <= LC_STALE) begin
                                state_next = S_HASH;
                            end
                        end
                        REQ_MARK, REQ_CONSUME: begin
                            if ({1'b0, s_layer_kind} < KINDS_W) begin
                                state_next = S_HASH;
                            end
                        end
                        REQ_SWEEP: begin
                            sts_next   = STS_SAME;
                            state_next = S_SW_RD;
                        end
                        default: begin
                            sts_next = STS_BADARG;
                        end
                    endcase
                end
            end

            // fold one key field per cycle into the hash
            S_HASH: begin
                case (step_reg)
                    5'd0:    mix_v = {29'd0, kind_reg};
                    5'd1:    mix_v = {27'd0, z_reg};
                    5'd2:    mix_v = {1'b0, x_reg};
                    5'd3:    mix_v = {1'b0, y_reg};
                    default: mix_v = {29'd0, band_reg};
                endcase
                h_next    = hash_mix(h_reg, mix_v);
                step_next = step_reg + 1'b1;
                if (step_reg == 5'd4) begin
                    step_next  = '0;
                    idx_next   = '0;
                    state_next = S_MOD;
                end
            end

            // home slot: multiply by the reciprocal, then subtract the quotient multiple
            S_MOD: begin
                step_next = step_reg + 1'b1;
                case (step_reg)
                    5'd0: begin
                        mul_lo    = h_reg * RECIP_LO;
                        prod_next = {1'b0, mul_lo} +
                                    (RECIP_HI ? {1'b0, h_reg, 32'd0} : 65'd0);
                    end
                    5'd1: begin
                        quo     = 32'(prod_reg >> (32 + IW));
                        qn_next = quo * SLOTS_32;
                    end
                    default: begin
                        rem_w       = h_reg - qn_reg;
                        idx_next    = rem_w[IW-1:0];
                        cnt_next    = '0;
                        fb_vld_next = 1'b0;
                        state_next  = S_RD;
                    end
                endcase
            end

            S_RD: begin
                state_next = S_CHK;
            end

            // compare one probed slot
            S_CHK: begin
                new_ent = '{tag: key_tag, col: x_reg, row: y_reg, stat: '0, frame: '0};
                if (!rd_ent.tag[0]) begin
                    if (!create) begin
                        sts_next   = STS_NOSLOT;
                        state_next = S_FIN;
                    end else begin
                        ent_next   = new_ent;
                        idx_next   = fb_vld_reg ? fb_idx_reg : idx_reg;
                        state_next = S_APPLY;
                    end
                end else if (rd_ent.tag == key_tag && rd_ent.col == x_reg &&
                             rd_ent.row == y_reg) begin
                    ent_next   = rd_ent;
                    state_next = S_APPLY;
                end else begin
                    fb_take = !fb_vld_reg || (rd_ent.frame < fb_frame_reg);
                    fb_sel  = fb_take ? idx_reg : fb_idx_reg;
                    if (fb_take) begin
                        fb_vld_next   = 1'b1;
                        fb_idx_next   = idx_reg;
                        fb_frame_next = rd_ent.frame;
                    end
                    cnt_next = cnt_reg + 1'b1;
                    idx_next = idx_inc;
                    state_next = S_RD;
                    if (cnt_reg == SLOTS_W - 1'b1) begin
                        if (!create) begin
                            sts_next   = STS_NOSLOT;
                            state_next = S_FIN;
                        end else begin
                            ent_next   = new_ent;
                            idx_next   = fb_sel;
                            state_next = S_APPLY;
                        end
                    end
                end
            end

            // apply the request to the found entry and write it back
            S_APPLY: begin
                ram_we     = 1'b1;
                state_next = S_FIN;
                new_ent    = ent_reg;
                case (req_reg)
                    REQ_TRANS: begin
                        if (!legal) begin
                            stat_next[1] = stat_reg[1] + 1'b1;
                            stat_next[2] = stat_reg[2] + 1'b1;
                            sts_next     = STS_ILLEGAL;
                        end else begin
                            new_ent.stat  = {ent_reg.stat[7], flags_reg, nst_reg};
                            new_ent.frame = fc_reg;
                            if (nst_reg == LC_STALE) begin
                                new_ent.stat[7] = 1'b0;
                            end
                            if (prev_st != nst_reg) begin
                                stat_next[0]     = stat_reg[0] + 1'b1;
                                per_next[nst_reg] = per_reg[nst_reg] + 1'b1;
                                sts_next         = STS_CHANGED;
                            end else begin
                                sts_next = STS_SAME;
                            end
                            if (nst_reg == LC_RENDER) begin
                                if (flags_reg[3]) begin
                                    stat_next[3] = stat_reg[3] + 1'b1;
                                end else if (flags_reg[2]) begin
                                    stat_next[4] = stat_reg[4] + 1'b1;
                                end
                            end
                        end
                    end
                    REQ_MARK: begin
                        sts_next        = ent_reg.stat[7] ? STS_SAME : STS_CHANGED;
                        new_ent.stat[7] = 1'b1;
                    end
                    default: begin
                        if (ent_reg.stat[7]) begin
                            new_ent.stat[7] = 1'b0;
                            sts_next        = STS_CHANGED;
                            retry_next      = 1'b1;
                        end else begin
                            sts_next = STS_SAME;
                        end
                    end
                endcase
                ram_wdata = new_ent;
            end

            S_SW_RD: begin
                state_next = S_SW_CHK;
            end

            // age one live slot outside the window to stale
            S_SW_CHK: begin
                in_win = (rd_ent.tag[11:7] == z_reg) &&
                         (rd_ent.col >= x_reg) && (rd_ent.col <= rx_reg) &&
                         (rd_ent.row >= y_reg) && (rd_ent.row <= by_reg);
                move = rd_ent.tag[0] && (rd_ent.stat[2:0] != LC_ABSENT) &&
                       (rd_ent.stat[2:0] != LC_STALE) && !in_win;
                new_ent       = rd_ent;
                new_ent.stat  = {3'b000, rd_ent.stat[4:3], LC_STALE};
                new_ent.frame = fc_reg;
                ram_wdata     = new_ent;
                if (move) begin
                    ram_we             = 1'b1;
                    stat_next[0]       = stat_reg[0] + 1'b1;
                    per_next[LC_STALE] = per_reg[LC_STALE] + 1'b1;
                    sts_next           = STS_CHANGED;
                end
                idx_next   = idx_inc;
                state_next = (idx_reg == LAST_IDX) ? S_FIN : S_SW_RD;
            end

            // load the result register when it is free
            S_FIN: begin
                tgt = (req_reg == REQ_SWEEP) ? LC_STALE : nst_reg;
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = sts_reg;
                    m_retry_next  = retry_reg;
                    m_fn_next     = fc_reg;
                    m_ft_next     = stat_reg[0];
                    m_fi_next     = stat_reg[1];
                    m_it_next     = stat_reg[2];
                    m_id_next     = stat_reg[3];
                    m_fb_next     = stat_reg[4];
                    m_tc_next     = (tgt <= LC_STALE) ? per_reg[tgt] : '0;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            idx_reg     <= '0;
            fc_reg      <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 5; i++) begin
                stat_reg[i] <= '0;
            end
            for (int i = 0; i < 6; i++) begin
                per_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            fc_reg      <= fc_next;
            m_valid_reg <= m_valid_next;
            stat_reg    <= stat_next;
            per_reg     <= per_next;
        end
        fb_idx_reg    <= fb_idx_next;
        fb_vld_reg    <= fb_vld_next;
        fb_frame_reg  <= fb_frame_next;
        cnt_reg       <= cnt_next;
        step_reg      <= step_next;
        h_reg         <= h_next;
        prod_reg      <= prod_next;
        qn_reg        <= qn_next;
        req_reg       <= req_next;
        kind_reg      <= kind_next;
        z_reg         <= z_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        band_reg      <= band_next;
        nst_reg       <= nst_next;
        flags_reg     <= flags_next;
        rx_reg        <= rx_next;
        by_reg        <= by_next;
        ent_reg       <= ent_next;
        sts_reg       <= sts_next;
        retry_reg     <= retry_next;
        m_status_reg  <= m_status_next;
        m_retry_reg   <= m_retry_next;
        m_fn_reg      <= m_fn_next;
        m_ft_reg      <= m_ft_next;
        m_fi_reg      <= m_fi_next;
        m_it_reg      <= m_it_next;
        m_id_reg      <= m_id_next;
        m_fb_reg      <= m_fb_next;
        m_tc_reg      <= m_tc_next;
    end
endmodule
`default_nettype wire
